// ----- src/sep2d_pkg.sv -----
// shared types, widths and register indexes of the separable 3x3 convolution unit
// no dependencies

package sep2d_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int TAP_W        = 16;
    localparam int DIM_W        = 11;
    localparam int OUT_IDX_W    = 10;
    localparam int VPROD_W      = 2 * SAMPLE_W;
    localparam int VERT_W       = VPROD_W + 2;
    localparam int HPROD_W      = TAP_W + VERT_W;
    localparam int RES_W        = 56;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 80;
    localparam int CFG_IDX_W    = 3;
    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;
    localparam int OUT_DEPTH    = 8;

    localparam logic [CFG_IDX_W-1:0] REG_VERT_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERT_MID    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERT_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZ_FIRST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZ_MID   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZ_LAST  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_W     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_H     = 3'd7;

    localparam logic signed [TAP_W-1:0] TAP_UNITY = 16'sd4096;
    localparam logic [DIM_W-1:0]        DIM_RESET = 11'd1024;

    typedef struct packed {
        logic signed [TAP_W-1:0] vert_top;
        logic signed [TAP_W-1:0] vert_mid;
        logic signed [TAP_W-1:0] vert_low;
        logic signed [TAP_W-1:0] horiz_first;
        logic signed [TAP_W-1:0] horiz_mid;
        logic signed [TAP_W-1:0] horiz_last;
    } taps_t;

    typedef struct packed {
        logic                 do_vert;
        logic                 first_col;
        logic                 emit;
        logic                 row_end;
        logic                 frame_end;
        logic [OUT_IDX_W-1:0] out_row;
        logic [OUT_IDX_W-1:0] out_col;
    } ctrl_t;

    typedef struct packed {
        logic                    frame_end;
        logic [OUT_IDX_W-1:0]    out_col;
        logic [OUT_IDX_W-1:0]    out_row;
        logic signed [RES_W-1:0] filtered;
    } result_t;

endpackage

// ----- src/sep2d_cfg_regs.sv -----
// configuration registers and frame geometry clamping
// depends on sep2d_pkg

module sep2d_cfg_regs
    import sep2d_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int COL_W = $clog2(MAX_COLS + 1),
    localparam int ROW_W = $clog2(MAX_ROWS + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TAP_W-1:0]     cfg_data,
    output taps_t                taps,
    output logic [COL_W-1:0]     cols,
    output logic [ROW_W-1:0]     rows
);

    taps_t            taps_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg.vert_top    <= '0;
            taps_reg.vert_mid    <= TAP_UNITY;
            taps_reg.vert_low    <= '0;
            taps_reg.horiz_first <= '0;
            taps_reg.horiz_mid   <= TAP_UNITY;
            taps_reg.horiz_last  <= '0;
            width_reg            <= DIM_RESET;
            height_reg           <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VERT_TOP:    taps_reg.vert_top    <= cfg_data;
                REG_VERT_MID:    taps_reg.vert_mid    <= cfg_data;
                REG_VERT_LOW:    taps_reg.vert_low    <= cfg_data;
                REG_HORIZ_FIRST: taps_reg.horiz_first <= cfg_data;
                REG_HORIZ_MID:   taps_reg.horiz_mid   <= cfg_data;
                REG_HORIZ_LAST:  taps_reg.horiz_last  <= cfg_data;
                REG_FRAME_W:     width_reg            <= cfg_data[DIM_W-1:0];
                REG_FRAME_H:     height_reg           <= cfg_data[DIM_W-1:0];
                default:         ;
            endcase
        end
    end

    assign taps = taps_reg;

    // zero counts as one, large values saturate
    always_comb
    begin
        if (width_reg == '0)
            cols = COL_W'(1);
        else if (32'(width_reg) > MAX_COLS)
            cols = COL_W'(MAX_COLS);
        else
            cols = COL_W'(width_reg);

        if (height_reg == '0)
            rows = ROW_W'(1);
        else if (32'(height_reg) > MAX_ROWS)
            rows = ROW_W'(MAX_ROWS);
        else
            rows = ROW_W'(height_reg);
    end

endmodule

// ----- src/sep2d_line_store.sv -----
// line buffer memory holding the two previous rows, one entry per column
// depends on sep2d_pkg; registered synchronous read with write forwarding

module sep2d_line_store
    import sep2d_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    localparam int ADDR_W = $clog2(MAX_COLS)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic signed [SAMPLE_W-1:0] wr_current,
    input  logic signed [SAMPLE_W-1:0] wr_above,
    output logic signed [SAMPLE_W-1:0] rd_current,
    output logic signed [SAMPLE_W-1:0] rd_above
);

    localparam int ENTRY_W = 2 * SAMPLE_W;

    logic [ENTRY_W-1:0] mem [MAX_COLS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;
    logic               fwd_hit_reg;
    logic [ENTRY_W-1:0] entry;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {wr_above, wr_current};
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
        fwd_data_reg <= {wr_above, wr_current};
    end

    // read and write of the same column at one edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_hit_reg <= 1'b0;
        else
            fwd_hit_reg <= rd_en && wr_en && (rd_addr == wr_addr);
    end

    assign entry      = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign rd_current = entry[SAMPLE_W-1:0];
    assign rd_above   = entry[ENTRY_W-1:SAMPLE_W];

endmodule

// ----- src/sep2d_vert_stage.sv -----
// stream position tracking and vertical 3-tap convolution pipeline
// depends on sep2d_pkg and sep2d_line_store

module sep2d_vert_stage
    import sep2d_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int COL_W = $clog2(MAX_COLS + 1),
    localparam int ROW_W = $clog2(MAX_ROWS + 1)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_flush,
    input  logic signed [SAMPLE_W-1:0] in_sample,
    input  taps_t                      taps,
    input  logic [COL_W-1:0]           cols,
    input  logic [ROW_W-1:0]           rows,
    output logic                       out_valid,
    output ctrl_t                      out_ctrl,
    output logic signed [VERT_W-1:0]   out_v
);

    localparam int IDX_W = $clog2(MAX_COLS);
    localparam int IR_W  = $clog2(MAX_ROWS + 2);

    logic [IR_W-1:0]  ir_reg;
    logic [IDX_W-1:0] ic_reg;

    logic [IR_W-1:0]             rows_x;
    logic                        row_start;
    logic                        past_frame;
    logic                        frame_done;
    logic                        row_wrap;
    ctrl_t                       ctrl0;
    logic signed [SAMPLE_W-1:0]  x0;

    logic                        s1_valid_reg;
    ctrl_t                       s1_ctrl_reg;
    logic signed [SAMPLE_W-1:0]  s1_x_reg;
    logic [IDX_W-1:0]            s1_idx_reg;
    logic                        s1_above_ok_reg;
    logic signed [SAMPLE_W-1:0]  line_cur;
    logic signed [SAMPLE_W-1:0]  line_abv;
    logic signed [SAMPLE_W-1:0]  above_op;

    logic                        s2_valid_reg;
    ctrl_t                       s2_ctrl_reg;
    logic signed [VPROD_W-1:0]   p_top_reg;
    logic signed [VPROD_W-1:0]   p_mid_reg;
    logic signed [VPROD_W-1:0]   p_low_reg;

    logic                        v_valid_reg;
    ctrl_t                       v_ctrl_reg;
    logic signed [VERT_W-1:0]    v_reg;

    always_comb
    begin
        rows_x     = IR_W'(rows);
        row_start  = (ic_reg == '0);
        past_frame = (ir_reg >= rows_x);
        frame_done = row_start && (ir_reg >= rows_x + IR_W'(1));
        row_wrap   = (COL_W'(ic_reg) + COL_W'(1)) >= cols;

        ctrl0.row_end   = row_start && (ir_reg >= IR_W'(2));
        ctrl0.frame_end = frame_done;
        ctrl0.do_vert   = (ir_reg != '0) && !frame_done;
        ctrl0.first_col = row_start;
        ctrl0.emit      = ctrl0.row_end || ((ir_reg != '0) && !row_start);
        if (ctrl0.row_end)
        begin
            ctrl0.out_row = OUT_IDX_W'(ir_reg - IR_W'(2));
            ctrl0.out_col = OUT_IDX_W'(cols - COL_W'(1));
        end
        else
        begin
            ctrl0.out_row = OUT_IDX_W'(ir_reg - IR_W'(1));
            ctrl0.out_col = OUT_IDX_W'(ic_reg - IDX_W'(1));
        end

        if (in_flush || past_frame)
            x0 = '0;
        else
            x0 = in_sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_reg <= '0;
            ic_reg <= '0;
        end
        else if (in_valid)
        begin
            if (frame_done)
            begin
                ir_reg <= '0;
                ic_reg <= '0;
            end
            else if (row_wrap)
            begin
                ic_reg <= '0;
                ir_reg <= ir_reg + IR_W'(1);
            end
            else
            begin
                ic_reg <= ic_reg + IDX_W'(1);
            end
        end
    end

    sep2d_line_store #(
        .MAX_COLS(MAX_COLS)
    ) u_line_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (in_valid),
        .rd_addr    (ic_reg),
        .wr_en      (s1_valid_reg && !s1_ctrl_reg.frame_end),
        .wr_addr    (s1_idx_reg),
        .wr_current (s1_x_reg),
        .wr_above   (line_cur),
        .rd_current (line_cur),
        .rd_above   (line_abv)
    );

    assign above_op = s1_above_ok_reg ? line_abv : 16'sd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            v_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            v_valid_reg  <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s1_ctrl_reg     <= ctrl0;
            s1_x_reg        <= x0;
            s1_idx_reg      <= ic_reg;
            s1_above_ok_reg <= (ir_reg >= IR_W'(2));
        end
        s2_ctrl_reg <= s1_ctrl_reg;
        p_top_reg   <= taps.vert_top * s1_x_reg;
        p_mid_reg   <= taps.vert_mid * line_cur;
        p_low_reg   <= taps.vert_low * above_op;
        v_ctrl_reg  <= s2_ctrl_reg;
        v_reg       <= VERT_W'(p_top_reg) + VERT_W'(p_mid_reg) + VERT_W'(p_low_reg);
    end

    assign out_valid = v_valid_reg;
    assign out_ctrl  = v_ctrl_reg;
    assign out_v     = v_reg;

endmodule

// ----- src/sep2d_horiz_stage.sv -----
// vertical result window and horizontal 3-tap convolution
// depends on sep2d_pkg

module sep2d_horiz_stage
    import sep2d_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  ctrl_t                    in_ctrl,
    input  logic signed [VERT_W-1:0] in_v,
    input  taps_t                    taps,
    output logic                     res_valid,
    output logic                     res_none,
    output result_t                  res
);

    logic signed [VERT_W-1:0]  w1_reg;
    logic signed [VERT_W-1:0]  w2_reg;
    logic signed [VERT_W-1:0]  right_op;

    logic                      h_valid_reg;
    ctrl_t                     h_ctrl_reg;
    logic signed [HPROD_W-1:0] hp_last_reg;
    logic signed [HPROD_W-1:0] hp_mid_reg;
    logic signed [HPROD_W-1:0] hp_first_reg;

    // at a row end the right neighbour lies outside the frame
    always_comb
    begin
        if (in_ctrl.row_end)
            right_op = '0;
        else
            right_op = in_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_reg      <= '0;
            w2_reg      <= '0;
            h_valid_reg <= 1'b0;
        end
        else
        begin
            h_valid_reg <= in_valid;
            if (in_valid)
            begin
                if (in_ctrl.frame_end)
                begin
                    w1_reg <= '0;
                    w2_reg <= '0;
                end
                else if (in_ctrl.do_vert)
                begin
                    if (in_ctrl.first_col)
                        w1_reg <= '0;
                    else
                        w1_reg <= w2_reg;
                    w2_reg <= in_v;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        h_ctrl_reg   <= in_ctrl;
        hp_last_reg  <= taps.horiz_last * w1_reg;
        hp_mid_reg   <= taps.horiz_mid * w2_reg;
        hp_first_reg <= taps.horiz_first * right_op;
    end

    always_comb
    begin
        res.filtered  = RES_W'(hp_last_reg) + RES_W'(hp_mid_reg) + RES_W'(hp_first_reg);
        res.out_row   = h_ctrl_reg.out_row;
        res.out_col   = h_ctrl_reg.out_col;
        res.frame_end = h_ctrl_reg.frame_end;
    end

    assign res_valid = h_valid_reg && h_ctrl_reg.emit;
    assign res_none  = h_valid_reg && !h_ctrl_reg.emit;

endmodule

// ----- src/sep2d_out_fifo.sv -----
// output queue with slot credit covering items still in the pipeline
// depends on sep2d_pkg

module sep2d_out_fifo
    import sep2d_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    take,
    input  logic    push,
    input  logic    release_slot,
    input  result_t push_data,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    result_t          entries [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] reserved_reg;
    logic [CNT_W-1:0] reserved_next;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = entries[rd_ptr_reg];
    assign space     = (reserved_reg < CNT_W'(OUT_DEPTH));

    always_comb
    begin
        reserved_next = reserved_reg + CNT_W'(take) - CNT_W'(pop) - CNT_W'(release_slot);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
            reserved_reg <= '0;
        end
        else
        begin
            reserved_reg <= reserved_next;
            count_reg    <= count_reg + CNT_W'(push) - CNT_W'(pop);
            if (push)
            begin
                if (wr_ptr_reg == PTR_W'(OUT_DEPTH - 1))
                    wr_ptr_reg <= '0;
                else
                    wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                if (rd_ptr_reg == PTR_W'(OUT_DEPTH - 1))
                    rd_ptr_reg <= '0;
                else
                    rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

// ----- src/separable_2d_convolution_unit.sv -----
// separable 3x3 convolution over a raster-order stream, vertical then horizontal taps
// a result passes the vertical stage registers s1, s2 and v, the horizontal product registers and the output queue
// throughput: one transaction per cycle, bounded by the 8-slot output queue credit
// reset: position, window and registers return to defaults; line memory is not cleared
// depends on sep2d_pkg, sep2d_cfg_regs, sep2d_vert_stage, sep2d_horiz_stage, sep2d_out_fifo

module separable_2d_convolution_unit
    import sep2d_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [TAP_W-1:0]       cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // sample
    input  logic                   s_axis_tuser,   // req_type
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // filtered, out_row, out_col, zero pad
    output logic                   m_axis_tlast
);

    localparam int COL_W = $clog2(MAX_COLS + 1);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int PAD_W = OUT_TDATA_W - RES_W - 2 * OUT_IDX_W;

    taps_t                    taps;
    logic [COL_W-1:0]         cols;
    logic [ROW_W-1:0]         rows;
    logic                     in_take;
    logic                     v_valid;
    ctrl_t                    v_ctrl;
    logic signed [VERT_W-1:0] v_value;
    logic                     res_valid;
    logic                     res_none;
    result_t                  res;
    result_t                  out_res;

    assign in_take = s_axis_tvalid && s_axis_tready;

    sep2d_cfg_regs #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .taps      (taps),
        .cols      (cols),
        .rows      (rows)
    );

    sep2d_vert_stage #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) u_vert_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_take),
        .in_flush  (s_axis_tuser),
        .in_sample (s_axis_tdata[SAMPLE_W-1:0]),
        .taps      (taps),
        .cols      (cols),
        .rows      (rows),
        .out_valid (v_valid),
        .out_ctrl  (v_ctrl),
        .out_v     (v_value)
    );

    sep2d_horiz_stage u_horiz_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_valid),
        .in_ctrl   (v_ctrl),
        .in_v      (v_value),
        .taps      (taps),
        .res_valid (res_valid),
        .res_none  (res_none),
        .res       (res)
    );

    sep2d_out_fifo u_out_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (in_take),
        .push         (res_valid),
        .release_slot (res_none),
        .push_data    (res),
        .space        (s_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (out_res)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, out_res.out_col, out_res.out_row, out_res.filtered};
    assign m_axis_tlast = out_res.frame_end;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for separable_2d_convolution_unit: directed and random frames with a
// transaction-level prediction of every filtered sample; depends on sep2d_pkg and the unit itself

module tb
    import sep2d_pkg::*;
;

    localparam int unsigned CYCLE_LIMIT   = 2000000;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned ITEM_TARGET   = 1650;

    class conv_checker;
        longint      v_top, v_mid, v_low, h_first, h_mid, h_last;
        logic [DIM_W-1:0] width_reg, height_reg;
        longint      older_row [DEF_MAX_COLS];
        longint      newer_row [DEF_MAX_COLS];
        longint      col_sums [3];
        int unsigned at_row, at_col;
        result_t     expected_results [$];
        int unsigned mismatches;

        function void clear();
            v_top = 0;
            v_mid = longint'(TAP_UNITY);
            v_low = 0;
            h_first = 0;
            h_mid = longint'(TAP_UNITY);
            h_last = 0;
            width_reg = DIM_RESET;
            height_reg = DIM_RESET;
            foreach (older_row[i]) older_row[i] = 0;
            foreach (newer_row[i]) newer_row[i] = 0;
            foreach (col_sums[i]) col_sums[i] = 0;
            at_row = 0;
            at_col = 0;
            mismatches = 0;
        endfunction

        function int unsigned dim_limit(logic [DIM_W-1:0] v, int unsigned maxv);
            if (v == 0) return 1;
            if (32'(v) > maxv) return maxv;
            return 32'(v);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TAP_W-1:0] val);
            case (idx)
                REG_VERT_TOP:    v_top = longint'($signed(val));
                REG_VERT_MID:    v_mid = longint'($signed(val));
                REG_VERT_LOW:    v_low = longint'($signed(val));
                REG_HORIZ_FIRST: h_first = longint'($signed(val));
                REG_HORIZ_MID:   h_mid = longint'($signed(val));
                REG_HORIZ_LAST:  h_last = longint'($signed(val));
                REG_FRAME_W:     width_reg = val[DIM_W-1:0];
                REG_FRAME_H:     height_reg = val[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void push_result(longint acc, logic [31:0] row, logic [31:0] col, bit last);
            result_t r;
            r.filtered = acc[RES_W-1:0];
            r.out_row = row[OUT_IDX_W-1:0];
            r.out_col = col[OUT_IDX_W-1:0];
            r.frame_end = last;
            expected_results.insert(expected_results.size(), r);
        endfunction

        // one input transaction: vertical sum for this column, then the horizontal tap
        function void note_input(logic req, logic [SAMPLE_W-1:0] smp);
            int unsigned cols, rows, idx;
            longint x, above, vsum, acc;
            cols = dim_limit(width_reg, DEF_MAX_COLS);
            rows = dim_limit(height_reg, DEF_MAX_ROWS);
            idx = at_col % DEF_MAX_COLS;
            x = (req || at_row >= rows) ? 0 : longint'($signed(smp));
            if (at_col == 0 && at_row >= 2)
            begin
                // right neighbour of the last column lies outside the frame
                acc = h_last * col_sums[1] + h_mid * col_sums[2];
                push_result(acc, at_row - 2, cols - 1, at_row >= rows + 1);
                if (at_row >= rows + 1)
                begin
                    at_row = 0;
                    at_col = 0;
                    foreach (col_sums[i]) col_sums[i] = 0;
                    return;
                end
            end
            if (at_row >= 1)
            begin
                above = (at_row >= 2) ? older_row[idx] : 0;
                vsum = v_top * x + v_mid * newer_row[idx] + v_low * above;
                if (at_col == 0)
                begin
                    col_sums[0] = 0;
                    col_sums[1] = 0;
                end
                else
                begin
                    col_sums[0] = col_sums[1];
                    col_sums[1] = col_sums[2];
                end
                col_sums[2] = vsum;
                if (at_col >= 1)
                begin
                    acc = h_last * col_sums[0] + h_mid * col_sums[1] + h_first * col_sums[2];
                    push_result(acc, at_row - 1, at_col - 1, 1'b0);
                end
            end
            older_row[idx] = newer_row[idx];
            newer_row[idx] = x;
            if (at_col + 1 >= cols)
            begin
                at_col = 0;
                at_row = at_row + 1;
            end
            else
            begin
                at_col = at_col + 1;
            end
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual row %0d col %0d value %0d",
                         $time, got.out_row, got.out_col, got.filtered);
                mismatches++;
                return;
            end
            exp = expected_results.pop_front();
            if (got.filtered !== exp.filtered)
            begin
                $display("%0t filtered mismatch: expected %0d actual %0d",
                         $time, exp.filtered, got.filtered);
                mismatches++;
            end
            if (got.out_row !== exp.out_row)
            begin
                $display("%0t out_row mismatch: expected %0d actual %0d",
                         $time, exp.out_row, got.out_row);
                mismatches++;
            end
            if (got.out_col !== exp.out_col)
            begin
                $display("%0t out_col mismatch: expected %0d actual %0d",
                         $time, exp.out_col, got.out_col);
                mismatches++;
            end
            if (got.frame_end !== exp.frame_end)
            begin
                $display("%0t frame_end mismatch: expected %0d actual %0d",
                         $time, exp.frame_end, got.frame_end);
                mismatches++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [TAP_W-1:0]       cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    conv_checker      sb = new();
    logic [TAP_W-1:0] reg_vals [8];
    logic [16:0]      frame_body [$];
    bit               tx_gaps_on;
    bit               rx_stalls_on;
    int unsigned      cycle_count = 0;

    separable_2d_convolution_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // transaction monitor on both sides
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_input(s_axis_tuser, s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result({m_axis_tlast, m_axis_tdata[75:0]});
    end

    function automatic int unsigned pick_gap(bit enabled);
        int unsigned r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [TAP_W-1:0] pick_tap();
        logic [31:0] u;
        u = $urandom;
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return TAP_UNITY;
            default: return u[TAP_W-1:0];
        endcase
    endfunction

    function automatic logic [16:0] frame_sample();
        logic [31:0] u;
        logic        req;
        u = $urandom;
        req = ($urandom_range(0, 15) == 0);
        case ($urandom_range(0, 15))
            0: return {req, 16'h8000};
            1: return {req, 16'h7fff};
            2: return {req, 16'hffff};
            default: return {req, u[15:0]};
        endcase
    endfunction

    function automatic logic [16:0] pad_sample();
        logic [31:0] u;
        u = $urandom;
        return {($urandom_range(0, 3) != 0), u[15:0]};
    endfunction

    // receiver side stalls
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (rx_stalls_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap(1'b1);
            end
        end
    end

    task automatic load_regs();
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data <= reg_vals[i];
            @(posedge clk);
            sb.set_reg(i[CFG_IDX_W-1:0], reg_vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_item(input logic req, input logic [SAMPLE_W-1:0] smp);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= smp;
        do @(posedge clk); while (!s_axis_tready);
        gap = pick_gap(tx_gaps_on);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // frame_body gives the leading transactions, the rest are random
    task automatic run_frame(output int unsigned sent);
        int unsigned cols, rows, body_len, drain_at;
        logic [16:0] it;
        cols = sb.dim_limit(reg_vals[REG_FRAME_W][DIM_W-1:0], DEF_MAX_COLS);
        rows = sb.dim_limit(reg_vals[REG_FRAME_H][DIM_W-1:0], DEF_MAX_ROWS);
        body_len = rows * cols;
        sent = body_len + cols + 1;
        drain_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, sent - 1) : sent;
        for (int unsigned i = 0; i < sent; i++)
        begin
            if (i == drain_at)
                wait_drained();
            if (i < frame_body.size())
                it = frame_body[i];
            else if (i < body_len)
                it = frame_sample();
            else
                it = pad_sample();
            send_item(it[16], it[15:0]);
        end
        frame_body.delete();
        wait_drained();
    endtask

    initial
    begin
        int unsigned sent, item_total, frame_no;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_VERT_TOP;
        cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= 1'b0;
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        item_total = 0;
        sb.clear();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extreme taps, flush inside the frame, live sample in the padding row
        reg_vals[REG_VERT_TOP] = 16'h7fff;
        reg_vals[REG_VERT_MID] = 16'h8000;
        reg_vals[REG_VERT_LOW] = 16'h7fff;
        reg_vals[REG_HORIZ_FIRST] = 16'h8000;
        reg_vals[REG_HORIZ_MID] = 16'h7fff;
        reg_vals[REG_HORIZ_LAST] = 16'h8000;
        reg_vals[REG_FRAME_W] = 16'd3;
        reg_vals[REG_FRAME_H] = 16'd3;
        load_regs();
        frame_body = {17'h08000, 17'h07fff, 17'h08000, 17'h07fff, 17'h17fff, 17'h00000,
                      17'h0ffff, 17'h08000, 17'h07fff, 17'h07fff, 17'h18000, 17'h11234,
                      17'h10000};
        run_frame(sent);
        item_total += sent;

        // zero geometry counts as one
        reg_vals[REG_VERT_TOP] = 16'hffff;
        reg_vals[REG_VERT_MID] = TAP_UNITY;
        reg_vals[REG_VERT_LOW] = 16'h0001;
        reg_vals[REG_HORIZ_FIRST] = 16'h0001;
        reg_vals[REG_HORIZ_MID] = TAP_UNITY;
        reg_vals[REG_HORIZ_LAST] = 16'hffff;
        reg_vals[REG_FRAME_W] = 16'd0;
        reg_vals[REG_FRAME_H] = 16'd0;
        load_regs();
        frame_body = {17'h07fff, 17'h10000, 17'h08000};
        run_frame(sent);
        item_total += sent;

        // largest magnitude everywhere
        for (int i = 0; i < 6; i++)
            reg_vals[i] = 16'h8000;
        reg_vals[REG_FRAME_W] = 16'd2;
        reg_vals[REG_FRAME_H] = 16'd2;
        load_regs();
        frame_body = {17'h08000, 17'h08000, 17'h08000, 17'h08000, 17'h18000, 17'h08000,
                      17'h1ffff};
        run_frame(sent);
        item_total += sent;

        frame_no = 0;
        while (item_total < ITEM_TARGET || frame_no <= 5)
        begin
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < 6; i++)
                reg_vals[i] = pick_tap();
            if (frame_no == 2)
            begin
                // bits above the geometry register width are dropped
                reg_vals[REG_FRAME_W] = 16'hf800;
                reg_vals[REG_FRAME_H] = 16'h0803;
            end
            else if (frame_no == 5)
            begin
                // oversized height saturates to the row limit
                reg_vals[REG_FRAME_W] = 16'd1;
                reg_vals[REG_FRAME_H] = 16'h07ff;
            end
            else
            begin
                reg_vals[REG_FRAME_W] = ($urandom_range(0, 9) == 0) ? 16'd0
                                                                     : 16'($urandom_range(1, 12));
                reg_vals[REG_FRAME_H] = ($urandom_range(0, 9) == 0) ? 16'd0
                                                                     : 16'($urandom_range(1, 8));
            end
            load_regs();
            run_frame(sent);
            item_total += sent;
            frame_no++;
        end

        wait_drained();
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
